### hdl/swmin_pkg.sv
// Shared constants, types and helpers for the sliding window minimum block.
// Used by the queue memory, the top level and the port checker.
package swmin_pkg;

  // Sizes of the queue and of the sample path.
  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ADDR_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int POS_W        = $clog2(4 * MAX_WINDOW);
  localparam int WIN_W        = 7;

  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [POS_W-1:0]               pos_t;
  typedef logic [WIN_W-1:0]               win_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BACK,
    ST_DONE
  } state_t;

  // One write request into the queue memory.
  typedef struct packed {
    logic    en;
    addr_t   addr;
    sample_t val;
    pos_t    pos;
  } wr_req_t;

  // Ring index helpers.
  function automatic addr_t ring_next(addr_t i);
    if (i == addr_t'(MAX_WINDOW - 1)) begin
      return '0;
    end
    return i + addr_t'(1);
  endfunction

  function automatic addr_t ring_prev(addr_t i);
    if (i == '0) begin
      return addr_t'(MAX_WINDOW - 1);
    end
    return i - addr_t'(1);
  endfunction

endpackage

### hdl/swmin_queue_mem.sv
// Queue storage of the sliding window minimum: sample values and position tags.
// One write port, two registered read ports (head and tail); depends on swmin_pkg.
module swmin_queue_mem
  import swmin_pkg::*;
(
  input  logic    clk,
  input  wr_req_t wr_req,
  input  addr_t   head_addr,
  input  addr_t   tail_addr,
  output sample_t head_val,
  output pos_t    head_pos,
  output sample_t tail_val
);

  sample_t val_mem [MAX_WINDOW];
  pos_t    pos_mem [MAX_WINDOW];

  sample_t head_val_r;
  pos_t    head_pos_r;
  sample_t tail_val_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      val_mem[wr_req.addr] <= wr_req.val;
      pos_mem[wr_req.addr] <= wr_req.pos;
    end
  end

  // Read ports; a write to the same address is passed through.
  always_ff @(posedge clk) begin
    if (wr_req.en && (wr_req.addr == head_addr)) begin
      head_val_r <= wr_req.val;
      head_pos_r <= wr_req.pos;
    end else begin
      head_val_r <= val_mem[head_addr];
      head_pos_r <= pos_mem[head_addr];
    end
    if (wr_req.en && (wr_req.addr == tail_addr)) begin
      tail_val_r <= wr_req.val;
    end else begin
      tail_val_r <= val_mem[tail_addr];
    end
  end

  assign head_val = head_val_r;
  assign head_pos = head_pos_r;
  assign tail_val = tail_val_r;

endmodule

### hdl/sliding_window_minimum.sv
// Sliding window minimum: for each signed sample request the block returns the
// minimum of the last window_length samples (all samples so far until the window
// has filled). Samples sit in a monotonic ring queue of 64 entries. A request
// passes through the front state, which expires old entries at the front, the
// back state, which drops larger entries at the back and pushes the sample, and
// the done state, which loads the result register once it is free; each check or
// pop works against the queue memory's registered read ports. The next request
// is taken in the cycle after the result is loaded, and a stalled result delays
// that load. Since every sample is pushed once and popped at most once, the
// entries expired and dropped average at most one per request. The input is
// not ready while a request is in progress. window_length is 1 after reset; 0
// acts as 1 and values above 64 act as 64. Write it only while the block is idle.
// Depends on swmin_pkg and swmin_queue_mem.
module sliding_window_minimum
  import swmin_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  // Sample requests.
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  // Results.
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_window_min,
  // Configuration.
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  win_t    cfg_window_length
);

  state_t  state_r, state_nxt;
  addr_t   head_r, head_nxt;
  addr_t   tail_r, tail_nxt;
  cnt_t    occ_r, occ_nxt;
  pos_t    spos_r, spos_nxt;
  win_t    win_len_r;
  sample_t sample_r;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_min_r;

  wr_req_t wr_req;
  sample_t head_val;
  pos_t    head_pos;
  sample_t tail_val;

  win_t    win_eff;
  pos_t    age;
  logic    expire;
  logic    drop;
  logic    out_free;

  function automatic pos_t sample_position_diff(pos_t a, pos_t b);
    return a - b;
  endfunction

  // Queue storage; reads follow the next head and tail so data lines up.
  swmin_queue_mem u_mem (
    .clk       (clk),
    .wr_req    (wr_req),
    .head_addr (head_nxt),
    .tail_addr (ring_prev(tail_nxt)),
    .head_val  (head_val),
    .head_pos  (head_pos),
    .tail_val  (tail_val)
  );

  // Effective window length, clamped to the queue size.
  always_comb begin
    if (win_len_r == '0) begin
      win_eff = win_t'(1);
    end else if (win_len_r > win_t'(MAX_WINDOW)) begin
      win_eff = win_t'(MAX_WINDOW);
    end else begin
      win_eff = win_len_r;
    end
  end

  // Compare logic: front age check and back value check.
  assign age      = sample_position_diff(spos_r, head_pos);
  assign expire   = (occ_r != '0) && (age >= pos_t'(win_eff));
  assign drop     = (occ_r != '0) && (tail_val > sample_r);
  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FRONT;
        end
      end
      ST_FRONT: begin
        if (!expire) begin
          state_nxt = ST_BACK;
        end
      end
      ST_BACK: begin
        if (!drop) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Queue pointers, memory write and result register control.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    spos_nxt      = spos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_req        = '{en: 1'b0, addr: tail_r, val: sample_r, pos: spos_r};
    unique case (state_r)
      ST_IDLE: ;
      ST_FRONT: begin
        if (expire) begin
          head_nxt = ring_next(head_r);
          occ_nxt  = occ_r - cnt_t'(1);
        end
      end
      ST_BACK: begin
        if (drop) begin
          tail_nxt = ring_prev(tail_r);
          occ_nxt  = occ_r - cnt_t'(1);
        end else if (occ_r < cnt_t'(MAX_WINDOW)) begin
          wr_req.en = 1'b1;
          tail_nxt  = ring_next(tail_r);
          occ_nxt   = occ_r + cnt_t'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          spos_nxt      = spos_r + pos_t'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      spos_r      <= '0;
      win_len_r   <= win_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      spos_r      <= spos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        win_len_r <= cfg_window_length;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_min_r <= head_val;
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;

endmodule

### hdl/swmin_checker.sv
// Port-level checker for the sliding window minimum block, bound to the top level.
// Depends on swmin_pkg.
module swmin_checker
  import swmin_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_window_min
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_min))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An accepted request keeps the input busy while the front and back checks run.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input ready too early after a request");

  // A new result does not rise right after a request is accepted.
  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised right after acceptance");

endmodule

bind sliding_window_minimum swmin_checker u_swmin_checker (.*);
